// ===== rtl/hba_pkg.sv =====
package hba_pkg;

	localparam int HEAP_GRANULES = 4096;
	localparam int GRANULE_BYTES = 16;
	localparam int GW = $clog2(HEAP_GRANULES);      // granule index width
	localparam int CW = GW + 1;                     // count width, holds HEAP_GRANULES
	localparam int GRANULE_SHIFT = $clog2(GRANULE_BYTES);
	localparam int REQ_W = 17;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_NEXT  = 2'd1;
	localparam logic [1:0] FIT_BEST  = 2'd2;
	localparam logic [1:0] FIT_WORST = 2'd3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_BADFREE = 2'd2;

	localparam logic REG_FIT  = 1'b0;
	localparam logic REG_HEAP = 1'b1;

	// header-granule word: header flag, used flag, payload size
	typedef struct packed {
		logic          hdr;
		logic          used;
		logic [GW-1:0] pay;
	} hdr_word_t;

endpackage

// ===== rtl/hba_mem.sv =====
module hba_mem import hba_pkg::*; #(
	parameter int W = 8,
	parameter int DEPTH = HEAP_GRANULES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/heap_block_allocator_core.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: operation; tdata: request_bytes, free_address
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: address, granted_granules
// cfg_*    in   cfg_we             cfg_index selects register, cfg_wdata value
//
// Allocate: accept, a chain walk reading one header a cycle from the header memory,
// header writes in S_AW1 (and S_AW2, S_AW3 on a split), the result. Free: header check,
// merges with a free next and a free previous block. Reset and every heap_granules write
// run a clearing pass over all 4096 header-memory entries; no transaction is taken then.
// A finished result sits in the output register; the next transaction is accepted
// while it waits, and only a second result stalls behind an unaccepted one.
module heap_block_allocator_core import hba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [16:0] request_bytes, [28:17] free_address
	input  logic             s_tuser,   // [0] operation
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [23:0]      m_tdata,   // [11:0] address, [23:12] granted_granules
	output logic [1:0]       m_tuser,   // [1:0] status
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CW-1:0]    cfg_wdata
);

	typedef enum logic [13:0] {
		S_CLR  = 14'b00000000000001,
		S_IDLE = 14'b00000000000010,
		S_ACHK = 14'b00000000000100,
		S_AW1  = 14'b00000000001000,
		S_AW2  = 14'b00000000010000,
		S_AW3  = 14'b00000000100000,
		S_FCHK = 14'b00000001000000,
		S_FN   = 14'b00000010000000,
		S_FNB  = 14'b00000100000000,
		S_FP0  = 14'b00001000000000,
		S_FP   = 14'b00010000000000,
		S_FPB  = 14'b00100000000000,
		S_DONE = 14'b01000000000000,
		S_SPARE_UNUSED_GUARD = 14'b10000000000000
	} state_t;

	state_t st_q;

	logic [1:0]    fit_q;
	logic [CW-1:0] heap_q;
	logic [GW-1:0] rover_q;
	logic          rover_valid_q;
	logic [GW-1:0] cnt_q;

	logic [GW-1:0] g_q, start_q, sel_g_q, sel_p_q, h_q, ph_q, prev_q;
	logic [CW-1:0] need_q;
	logic          phase_q, found_q;
	logic [1:0]    res_st_q;
	logic [GW-1:0] res_addr_q, res_gr_q;

	logic          m_valid_q;
	logic [1:0]    m_st_q;
	logic [GW-1:0] m_addr_q, m_gr_q;

	// header memory and prev-link memory
	logic          a_we, a_re, b_we, b_re;
	logic [GW-1:0] a_wa, a_ra, b_wa, b_ra, b_wd, b_rd;
	hdr_word_t     a_wd, a_rd;

	hba_mem #(.W($bits(hdr_word_t)), .DEPTH(HEAP_GRANULES)) u_hdr_mem (
		.clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd),
		.re(a_re), .raddr(a_ra), .rdata(a_rd)
	);

	hba_mem #(.W(GW), .DEPTH(HEAP_GRANULES)) u_prev_mem (
		.clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd),
		.re(b_re), .raddr(b_ra), .rdata(b_rd)
	);

	assign s_tready = (st_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_st_q;
	assign m_tdata  = {m_gr_q, m_addr_q};

	logic              s_acc;
	logic [REQ_W:0]    req_sum;
	logic [CW-1:0]     need_raw, need_in;
	logic [GW-1:0]     fa_in;
	logic [GW-1:0]     start_in;
	logic [CW-1:0]     nxt;        // next header after the block in hand
	logic              fits, better, split;
	logic [CW-1:0]     split_at, old_next, after_h, after_p;
	logic [GW-1:0]     merged;
	logic [CW-1:0]     heap_clamp;

	assign s_acc    = s_tvalid && s_tready;
	assign req_sum  = {1'b0, s_tdata[REQ_W-1:0]} + (REQ_W+1)'(GRANULE_BYTES - 1);
	assign need_raw = CW'(req_sum >> GRANULE_SHIFT);
	assign need_in  = (need_raw == '0) ? CW'(1) : need_raw;
	assign fa_in    = s_tdata[REQ_W +: GW];
	assign start_in = rover_valid_q ? rover_q : '0;

	assign nxt      = {1'b0, g_q} + CW'(1) + {1'b0, a_rd.pay};
	assign fits     = !a_rd.used && ({1'b0, a_rd.pay} >= need_q);
	assign better   = !found_q ||
	                  ((fit_q == FIT_BEST) ? (a_rd.pay < sel_p_q) : (a_rd.pay > sel_p_q));
	assign split    = ({1'b0, sel_p_q} >= need_q + CW'(1));
	assign split_at = {1'b0, sel_g_q} + CW'(1) + need_q;
	assign old_next = {1'b0, sel_g_q} + CW'(1) + {1'b0, sel_p_q};
	assign after_h  = {1'b0, h_q} + CW'(1) + {1'b0, ph_q};
	assign after_p  = {1'b0, prev_q} + CW'(1) + {1'b0, sel_p_q};
	// merged payload: block in hand plus the neighbour just read plus its header
	assign merged   = ph_q + a_rd.pay + GW'(1);

	assign heap_clamp = (cfg_wdata < CW'(2)) ? CW'(2) :
	                    (cfg_wdata > CW'(HEAP_GRANULES)) ? CW'(HEAP_GRANULES) : cfg_wdata;

	// memory port steering
	always_comb begin
		a_we = 1'b0; a_wa = '0; a_wd = '0;
		a_re = 1'b0; a_ra = '0;
		b_we = 1'b0; b_wa = '0; b_wd = '0;
		b_re = 1'b0; b_ra = '0;
		case (st_q)
			S_CLR: begin
				a_we = 1'b1;
				a_wa = cnt_q;
				if (cnt_q == '0) begin
					a_wd.hdr = 1'b1;
					a_wd.pay = GW'(heap_q - CW'(1));
				end
			end
			S_IDLE: begin
				if (s_acc) begin
					if (s_tuser == OP_ALLOC) begin
						a_re = 1'b1; a_ra = start_in;
					end else begin
						a_re = 1'b1; a_ra = fa_in - GW'(1);
						b_re = 1'b1; b_ra = fa_in - GW'(1);
					end
				end
			end
			S_ACHK: begin
				a_re = 1'b1;
				a_ra = (nxt < heap_q) ? nxt[GW-1:0] : '0;
			end
			S_AW1: begin
				a_we = 1'b1; a_wa = sel_g_q;
				a_wd.hdr = 1'b1; a_wd.used = 1'b1;
				a_wd.pay = split ? need_q[GW-1:0] : sel_p_q;
			end
			S_AW2: begin
				a_we = 1'b1; a_wa = split_at[GW-1:0];
				a_wd.hdr = 1'b1;
				a_wd.pay = sel_p_q - need_q[GW-1:0] - GW'(1);
				b_we = 1'b1; b_wa = split_at[GW-1:0]; b_wd = sel_g_q;
			end
			S_AW3: begin
				b_we = 1'b1; b_wa = old_next[GW-1:0]; b_wd = split_at[GW-1:0];
			end
			S_FCHK: begin
				if (a_rd.hdr && a_rd.used) begin
					a_we = 1'b1; a_wa = h_q;
					a_wd.hdr = 1'b1; a_wd.pay = a_rd.pay;
					a_re = 1'b1;
					a_ra = h_q + GW'(1) + a_rd.pay;
				end
			end
			S_FN: begin
				if (!a_rd.used) begin
					a_we = 1'b1; a_wa = g_q;
				end
			end
			S_FNB: begin
				a_we = 1'b1; a_wa = h_q;
				a_wd.hdr = 1'b1; a_wd.pay = ph_q;
				if (after_h < heap_q) begin
					b_we = 1'b1; b_wa = after_h[GW-1:0]; b_wd = h_q;
				end
			end
			S_FP0: begin
				a_re = 1'b1; a_ra = prev_q;
			end
			S_FP: begin
				if (a_rd.hdr && !a_rd.used) begin
					a_we = 1'b1; a_wa = h_q;
				end
			end
			S_FPB: begin
				a_we = 1'b1; a_wa = prev_q;
				a_wd.hdr = 1'b1; a_wd.pay = sel_p_q;
				if (after_p < heap_q) begin
					b_we = 1'b1; b_wa = after_p[GW-1:0]; b_wd = prev_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= S_CLR;
			cnt_q         <= '0;
			fit_q         <= FIT_FIRST;
			heap_q        <= CW'(HEAP_GRANULES);
			rover_q       <= '0;
			rover_valid_q <= 1'b0;
			m_valid_q     <= 1'b0;
		end else begin
			// the result stage reloads the output register itself
			if (m_valid_q && m_tready && (st_q != S_DONE || cfg_we))
				m_valid_q <= 1'b0;

			if (cfg_we) begin
				if (cfg_index == REG_FIT) begin
					fit_q <= cfg_wdata[1:0];
				end else begin
					heap_q        <= heap_clamp;
					rover_q       <= '0;
					rover_valid_q <= 1'b0;
					cnt_q         <= '0;
					st_q          <= S_CLR;
				end
			end else begin
				case (st_q)
					S_CLR: begin
						cnt_q <= cnt_q + GW'(1);
						if (cnt_q == GW'(HEAP_GRANULES - 1))
							st_q <= S_IDLE;
					end
					S_IDLE: begin
						if (s_acc) begin
							if (s_tuser == OP_ALLOC) begin
								need_q  <= need_in;
								g_q     <= start_in;
								start_q <= start_in;
								phase_q <= 1'b0;
								found_q <= 1'b0;
								st_q    <= S_ACHK;
							end else if (fa_in == '0 || {1'b0, fa_in} >= heap_q) begin
								res_st_q   <= ST_BADFREE;
								res_addr_q <= '0;
								res_gr_q   <= '0;
								st_q       <= S_DONE;
							end else begin
								h_q  <= fa_in - GW'(1);
								st_q <= S_FCHK;
							end
						end
					end
					S_ACHK: begin
						// a_rd holds the header of g_q; the next header is read meanwhile
						if (fit_q == FIT_FIRST || fit_q == FIT_NEXT) begin
							if (fits) begin
								sel_g_q <= g_q;
								sel_p_q <= a_rd.pay;
								if (fit_q == FIT_NEXT) begin
									rover_q       <= g_q;
									rover_valid_q <= 1'b1;
								end
								st_q <= S_AW1;
							end else if (nxt < heap_q && !(fit_q == FIT_NEXT && phase_q &&
							             nxt[GW-1:0] == start_q)) begin
								g_q <= nxt[GW-1:0];
							end else if (fit_q == FIT_NEXT && !phase_q && start_q != '0) begin
								// wrap: restart the walk from granule zero
								phase_q <= 1'b1;
								g_q     <= '0;
							end else begin
								res_st_q   <= ST_NOFIT;
								res_addr_q <= '0;
								res_gr_q   <= '0;
								st_q       <= S_DONE;
							end
						end else begin
							if (fits && better) begin
								sel_g_q <= g_q;
								sel_p_q <= a_rd.pay;
								found_q <= 1'b1;
							end
							if (nxt < heap_q) begin
								g_q <= nxt[GW-1:0];
							end else if (found_q || fits) begin
								st_q <= S_AW1;
							end else begin
								res_st_q   <= ST_NOFIT;
								res_addr_q <= '0;
								res_gr_q   <= '0;
								st_q       <= S_DONE;
							end
						end
					end
					S_AW1: begin
						res_st_q   <= ST_OK;
						res_addr_q <= sel_g_q + GW'(1);
						res_gr_q   <= split ? need_q[GW-1:0] : sel_p_q;
						st_q       <= split ? S_AW2 : S_DONE;
					end
					S_AW2: begin
						st_q <= (old_next < heap_q) ? S_AW3 : S_DONE;
					end
					S_AW3: begin
						st_q <= S_DONE;
					end
					S_FCHK: begin
						if (!(a_rd.hdr && a_rd.used)) begin
							res_st_q   <= ST_BADFREE;
							res_addr_q <= '0;
							res_gr_q   <= '0;
							st_q       <= S_DONE;
						end else begin
							ph_q   <= a_rd.pay;
							prev_q <= b_rd;
							g_q    <= h_q + GW'(1) + a_rd.pay;
							st_q   <= ({1'b0, h_q} + CW'(1) + {1'b0, a_rd.pay} < heap_q) ?
							          S_FN : S_FP0;
						end
					end
					S_FN: begin
						if (!a_rd.used) begin
							ph_q <= merged;
							if (rover_valid_q && rover_q == g_q)
								rover_q <= h_q;
							st_q <= S_FNB;
						end else begin
							st_q <= S_FP0;
						end
					end
					S_FNB: begin
						st_q <= S_FP0;
					end
					S_FP0: begin
						res_st_q   <= ST_OK;
						res_addr_q <= h_q + GW'(1);
						res_gr_q   <= '0;
						st_q       <= (h_q != '0 && {1'b0, prev_q} < heap_q) ? S_FP : S_DONE;
					end
					S_FP: begin
						if (a_rd.hdr && !a_rd.used) begin
							sel_p_q <= merged;
							if (rover_valid_q && rover_q == h_q)
								rover_q <= prev_q;
							st_q <= S_FPB;
						end else begin
							st_q <= S_DONE;
						end
					end
					S_FPB: begin
						st_q <= S_DONE;
					end
					S_DONE: begin
						if (!m_valid_q || m_tready) begin
							m_valid_q <= 1'b1;
							m_st_q    <= res_st_q;
							m_addr_q  <= res_addr_q;
							m_gr_q    <= res_gr_q;
							st_q      <= S_IDLE;
						end
					end
					default: st_q <= S_IDLE;
				endcase
			end
		end
	end

	// no transaction during the clearing pass
	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLR) |-> !s_tready)
		else $error("input taken during clearing pass");

	// the pass runs on until its last entry
	a_clr_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLR && cnt_q != GW'(HEAP_GRANULES - 1) && !cfg_we) |=> (st_q == S_CLR))
		else $error("clearing pass ended early");

	// a pending result is never overwritten before it is taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> m_valid_q)
		else $error("result lost");

	// a failed allocate or bad free reports no address
	a_fail_null: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_st_q != ST_OK) |-> (m_addr_q == '0 && m_gr_q == '0))
		else $error("failure carries an address");

endmodule

// ===== bench/heap_block_allocator_core_chk.sv =====
module heap_block_allocator_core_chk import hba_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tready,
	input  logic [31:0]   s_tdata,
	input  logic          s_tuser,
	input  logic          m_tvalid,
	input  logic          m_tready,
	input  logic [23:0]   m_tdata,
	input  logic [1:0]    m_tuser,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [CW-1:0] cfg_wdata,
	output int            errors,
	output int            pending,
	output int            checked
);

	typedef struct {
		logic [1:0]    status;
		logic [GW-1:0] addr;
		logic [GW-1:0] gran;
	} alloc_result_t;

	alloc_result_t result_q[$];

	// shadow heap
	logic [1:0] policy;
	int         heap_size;
	bit         hdr[HEAP_GRANULES];
	bit         used[HEAP_GRANULES];
	int         pay[HEAP_GRANULES];
	int         prv[HEAP_GRANULES];
	int         rover;
	bit         rover_ok;

	task automatic reform_heap();
		for (int i = 0; i < HEAP_GRANULES; i++) begin
			hdr[i] = 0;
			used[i] = 0;
			pay[i] = 0;
			prv[i] = 0;
		end
		hdr[0] = 1;
		pay[0] = heap_size - 1;
		rover = 0;
		rover_ok = 0;
	endtask

	// -1 marks the end of the chain
	function automatic int follow(int g);
		int n;
		n = g + 1 + pay[g];
		return (n < heap_size) ? n : -1;
	endfunction

	function automatic bit usable(int g, int need);
		return !used[g] && pay[g] >= need;
	endfunction

	task automatic choose_block(input int need, output int pick);
		int start;
		pick = -1;
		if (policy == FIT_NEXT) begin
			start = rover_ok ? rover : 0;
			for (int g = start; g != -1; g = follow(g))
				if (usable(g, need)) begin
					pick = g;
					break;
				end
			if (pick == -1 && start != 0)
				for (int g = 0; g != -1 && g != start; g = follow(g))
					if (usable(g, need)) begin
						pick = g;
						break;
					end
			if (pick != -1) begin
				rover = pick;
				rover_ok = 1;
			end
			return;
		end
		for (int g = 0; g != -1; g = follow(g)) begin
			if (!usable(g, need))
				continue;
			if (policy == FIT_FIRST) begin
				pick = g;
				return;
			end
			if (pick == -1)
				pick = g;
			else if (policy == FIT_BEST && pay[g] < pay[pick])
				pick = g;
			else if (policy == FIT_WORST && pay[g] > pay[pick])
				pick = g;
		end
	endtask

	task automatic merge_next(int a, int b);
		int after;
		pay[a] += pay[b] + 1;
		hdr[b] = 0;
		used[b] = 0;
		after = follow(a);
		if (after != -1)
			prv[after] = a;
		if (rover_ok && rover == b)
			rover = a;
	endtask

	task automatic predict(input logic op, input int bytes, input int fa,
			output alloc_result_t r);
		int need, g, old_next, s, h, n, p;
		r.status = ST_OK;
		r.addr = '0;
		r.gran = '0;
		if (op == OP_ALLOC) begin
			need = (bytes + GRANULE_BYTES - 1) / GRANULE_BYTES;
			if (need == 0)
				need = 1;
			choose_block(need, g);
			if (g == -1) begin
				r.status = ST_NOFIT;
			end else begin
				old_next = follow(g);
				used[g] = 1;
				if (pay[g] >= need + 1) begin
					s = g + 1 + need;
					hdr[s] = 1;
					used[s] = 0;
					pay[s] = pay[g] - need - 1;
					prv[s] = g;
					pay[g] = need;
					if (old_next != -1)
						prv[old_next] = s;
				end
				r.addr = GW'(g + 1);
				r.gran = GW'(pay[g]);
			end
		end else begin
			h = fa - 1;
			if (fa == 0 || fa >= heap_size || !hdr[h] || !used[h]) begin
				r.status = ST_BADFREE;
			end else begin
				n = follow(h);
				used[h] = 0;
				if (n != -1 && !used[n])
					merge_next(h, n);
				if (h != 0) begin
					p = prv[h];
					if (p < heap_size && hdr[p] && !used[p])
						merge_next(p, h);
				end
				r.addr = GW'(fa);
			end
		end
	endtask

	task automatic report(input string what, input int got, input int want);
		errors++;
		$display("MISMATCH %0s: got %0d, expected %0d (result %0d)", what, got, want, checked);
	endtask

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t exp_r, new_r;
		int v;
		if (!arst_n) begin
			policy = FIT_FIRST;
			heap_size = HEAP_GRANULES;
			reform_heap();
			result_q.delete();
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			// results first, so an early result cannot match an item taken this edge
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					report("outstanding results", 1, 0);
				end else begin
					exp_r = result_q.pop_front();
					if (m_tuser != exp_r.status)
						report("status", m_tuser, exp_r.status);
					if (m_tdata[11:0] != exp_r.addr)
						report("address", m_tdata[11:0], exp_r.addr);
					if (m_tdata[23:12] != exp_r.gran)
						report("granted_granules", m_tdata[23:12], exp_r.gran);
				end
				checked++;
			end
			if (cfg_we) begin
				if (cfg_index == REG_FIT) begin
					policy = cfg_wdata[1:0];
				end else begin
					v = cfg_wdata;
					heap_size = v < 2 ? 2 : (v > HEAP_GRANULES ? HEAP_GRANULES : v);
					reform_heap();
				end
			end
			if (s_tvalid && s_tready) begin
				predict(s_tuser, s_tdata[16:0], s_tdata[28:17], new_r);
				result_q.push_back(new_r);
			end
			pending <= result_q.size();
		end
	end

endmodule

// ===== bench/heap_block_allocator_core_tb.sv =====
module heap_block_allocator_core_tb import hba_pkg::*;;

	// Worst case per allocate is a walk over every header of a 4096-granule heap,
	// plus the clearing pass after reset and each heap-size write.
	localparam int CYCLE_LIMIT = 20000000;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [31:0]   s_tdata;   // [16:0] request_bytes, [28:17] free_address
	logic          s_tuser;   // [0] operation
	logic          m_tvalid;
	logic          m_tready;
	logic [23:0]   m_tdata;   // [11:0] address, [23:12] granted_granules
	logic [1:0]    m_tuser;   // [1:0] status
	logic          cfg_we;
	logic          cfg_index;
	logic [CW-1:0] cfg_wdata;

	int errors, pending, checked;
	int cycles;
	int sent;
	int burst_left;
	int hold_request;          // long receiver hold-off, in cycles
	int cur_heap;
	logic [GW-1:0] live_addr[$]; // granted payload addresses, feed for frees

	heap_block_allocator_core dut (.*);

	heap_block_allocator_core_chk chk (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_we, .cfg_index, .cfg_wdata,
		.errors, .pending, .checked
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// run-length watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Harvest granted addresses so frees mostly name live blocks.
	always @(posedge clk)
		if (m_tvalid && m_tready && m_tuser == ST_OK && m_tdata[23:12] != 0)
			live_addr.push_back(m_tdata[11:0]);

	// Receiver: periodically picks an always-ready, light or heavy stall pattern at
	// random; a hold-off request forces tready low for a long stretch.
	initial begin
		int mode, hold_left;
		mode = 0;
		hold_left = 0;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (cycles % 64 == 0)
				mode = $urandom_range(0, 2);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (mode == 0)
				m_tready <= 1'b1;
			else if (mode == 1)
				m_tready <= ($urandom_range(0, 3) != 0);
			else
				m_tready <= ($urandom_range(0, 9) < 3);
		end
	end

	task automatic drop_valid(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// One input transaction; bursts of random length with random gaps between.
	task automatic send_item(input logic op, input int bytes, input int fa);
		logic [16:0] b;
		logic [11:0] a;
		b = bytes[16:0];
		a = fa[11:0];
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, a, b};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0)
				drop_valid($urandom_range(1, 8));
		end
	endtask

	// Sender stops until every outstanding result is back (each result follows
	// its header writes), then idles before returning.
	task automatic drain();
		drop_valid(1);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[CW-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEAP) begin
			cur_heap = val < 2 ? 2 : (val > HEAP_GRANULES ? HEAP_GRANULES : val);
			live_addr.delete();
		end
	endtask

	// Mostly allocate/free sequences on live blocks; some noise frees and
	// oversize requests to hit the no-fit and bad-free paths. A nonzero hold
	// starts the receiver hold-off once the clearing pass is over.
	task automatic random_phase(input logic [1:0] pol, input int heap_val, input int n,
			input int hold);
		int k, sel, bytes;
		write_reg(REG_FIT, pol);
		write_reg(REG_HEAP, heap_val);
		wait (s_tready);
		hold_request = hold;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 55 || (sel < 90 && live_addr.size() == 0)) begin
				if ($urandom_range(0, 19) == 0)
					bytes = $urandom_range(0, 65536);
				else
					bytes = $urandom_range(0, cur_heap * GRANULE_BYTES / 6);
				send_item(OP_ALLOC, bytes, $urandom_range(0, 4095));
			end else if (sel < 90) begin
				k = $urandom_range(0, live_addr.size() - 1);
				send_item(OP_FREE, $urandom_range(0, 131071), live_addr[k]);
				live_addr.delete(k);
			end else begin
				send_item(OP_FREE, $urandom_range(0, 131071), $urandom_range(0, 4095));
			end
		end
		drain();
	endtask

	initial begin
		cycles = 0;
		sent = 0;
		burst_left = 1;
		hold_request = 0;
		cur_heap = HEAP_GRANULES;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = OP_ALLOC;
		cfg_we = 0;
		cfg_index = REG_FIT;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: reset config is first fit over the full heap.
		send_item(OP_ALLOC, 0, 0);        // zero bytes -> one granule, address 1
		send_item(OP_ALLOC, 1, 0);        // address 3
		send_item(OP_ALLOC, 16, 0);       // address 5
		send_item(OP_ALLOC, 17, 0);       // two granules, address 7
		send_item(OP_ALLOC, 65536, 0);    // 4096 granules, the size of the whole heap
		send_item(OP_ALLOC, 65535, 0);    // 4096 granules, still no fit
		send_item(OP_FREE, 0, 0);         // null free
		send_item(OP_FREE, 0, 4095);      // not a header
		send_item(OP_FREE, 0, 2);         // granule inside a payload
		send_item(OP_FREE, 131071, 3);    // plain free
		send_item(OP_FREE, 0, 3);         // double free
		send_item(OP_FREE, 0, 1);         // merges with the freed neighbor
		send_item(OP_FREE, 0, 7);
		send_item(OP_FREE, 0, 5);         // merges on both sides
		send_item(OP_ALLOC, 65519, 0);    // 4095 granules: whole heap, unsplit
		send_item(OP_FREE, 0, 1);
		drain();

		// Smallest heap (clamped from 0), no split header ever fits.
		write_reg(REG_HEAP, 0);
		send_item(OP_ALLOC, 16, 0);
		send_item(OP_ALLOC, 0, 0);
		send_item(OP_FREE, 0, 2);         // at or past the heap end
		send_item(OP_FREE, 0, 1);
		drain();

		random_phase(FIT_NEXT, 1, 60, 0);
		random_phase(FIT_BEST, 100, 90, 0);
		random_phase(FIT_WORST, 300, 90, 400); // block fills and stalls its input
		random_phase(FIT_FIRST, 1000, 90, 0);
		random_phase(FIT_NEXT, 200, 110, 0);
		random_phase(FIT_BEST, 64, 80, 0);
		random_phase(FIT_WORST, 8191, 70, 0); // clamps to the full heap
		random_phase(FIT_NEXT, 4096, 70, 0);

		repeat (50) @(posedge clk);
		$display("Ran %0d transactions, %0d results checked, over all four fit policies", sent, checked);
		$display("and heap sizes from the 2-granule minimum to the full %0d granules.", HEAP_GRANULES);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== heap_block_allocator_core.f =====
rtl/hba_pkg.sv
rtl/hba_mem.sv
rtl/heap_block_allocator_core.sv
bench/heap_block_allocator_core_chk.sv
bench/heap_block_allocator_core_tb.sv
